// ----- hdl/hsvc_pkg.sv -----
// Shared constants, stage payload types and helpers for the HSV to RGB pipeline.
`default_nettype none

package hsvc_pkg;

   localparam int FRAC_BITS = 12;
   localparam int HUE_W = 15;
   localparam int FIELD_W = 13;

   // internal channel width holds 0..ONE
   localparam int CW = FRAC_BITS + 1;
   localparam int CMP_W = (FIELD_W > CW) ? FIELD_W : CW;
   localparam logic [CW-1:0] ONE = CW'(64'd1 << FRAC_BITS);

   localparam int DEG_PER_SECTOR = 60;
   localparam int HUE_STEPS_PER_DEG = 64;
   localparam int HUE_PER_SECTOR = DEG_PER_SECTOR * HUE_STEPS_PER_DEG;
   localparam int SECTOR_MAX = ((1 << HUE_W) - 1) / HUE_PER_SECTOR;
   localparam int SEC_W = $clog2(SECTOR_MAX + 1);
   localparam int REM_W = $clog2(HUE_PER_SECTOR);

   // 3840 = 15 << 8: fraction = (rem << (F-8)) / 15 via reciprocal multiply
   localparam int SECTOR_SHIFT = 8;
   localparam int SECTOR_ODD = HUE_PER_SECTOR >> SECTOR_SHIFT;
   localparam int X_W = REM_W + FRAC_BITS - SECTOR_SHIFT;
   localparam int RECIP_SHIFT = X_W + $clog2(SECTOR_ODD);
   localparam int RECIP_W = RECIP_SHIFT - 3;
   localparam longint RECIP_VAL =
      ((64'd1 << RECIP_SHIFT) + SECTOR_ODD - 1) / SECTOR_ODD;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

   // sector codes
   localparam logic [SEC_W-1:0] SEC_RED = SEC_W'(0);
   localparam logic [SEC_W-1:0] SEC_YELLOW = SEC_W'(1);
   localparam logic [SEC_W-1:0] SEC_GREEN = SEC_W'(2);
   localparam logic [SEC_W-1:0] SEC_CYAN = SEC_W'(3);
   localparam logic [SEC_W-1:0] SEC_BLUE = SEC_W'(4);

   typedef struct packed {
      logic [CW-1:0]    sat;
      logic [CW-1:0]    val;
      logic [SEC_W-1:0] sector;
      logic [REM_W-1:0] rem;
   } split_type;

   typedef struct packed {
      logic [CW-1:0]        sat;
      logic [CW-1:0]        val;
      logic [SEC_W-1:0]     sector;
      logic [FRAC_BITS-1:0] frac;
      logic [CW-1:0]        p;
   } frac_type;

   typedef struct packed {
      logic [CW-1:0]    val;
      logic [SEC_W-1:0] sector;
      logic [CW-1:0]    p;
      logic [CW-1:0]    q_fac;
      logic [CW-1:0]    t_fac;
   } term_type;

   function automatic logic [FIELD_W-1:0] to_field(input logic [CW-1:0] x);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(x);
      return wide[FIELD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/hsv_to_rgb_convert_core.sv -----
// Top level of the fixed-point HSV to RGB converter.
// Request to response: four register stages, each with at most one multiplier level.
// Throughput: one transaction per cycle unless the response stalls.
// A stalled response holds its stage; stages behind it keep filling into bubbles.
// Reset: synchronous, active high; clears all stage valid bits, data is not reset.
`default_nettype none

module hsv_to_rgb_convert_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [hsvc_pkg::HUE_W-1:0]    req_hue,
   input  wire logic [hsvc_pkg::FIELD_W-1:0]  req_saturation,
   input  wire logic [hsvc_pkg::FIELD_W-1:0]  req_brightness,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [hsvc_pkg::FIELD_W-1:0]       rsp_red,
   output logic [hsvc_pkg::FIELD_W-1:0]       rsp_green,
   output logic [hsvc_pkg::FIELD_W-1:0]       rsp_blue
);
   import hsvc_pkg::*;

   logic      split_valid, split_ready;
   split_type split_data;
   logic      term_valid, term_ready;
   term_type  term_data;

   hsvc_hue_split u_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .out_valid  (split_valid),
      .out_ready  (split_ready),
      .out_data   (split_data)
   );

   hsvc_term_calc u_terms (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_data   (split_data),
      .out_valid (term_valid),
      .out_ready (term_ready),
      .out_data  (term_data)
   );

   hsvc_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (term_valid),
      .in_ready  (term_ready),
      .in_data   (term_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .red       (rsp_red),
      .green     (rsp_green),
      .blue      (rsp_blue)
   );

endmodule

`default_nettype wire

// ----- hdl/hsvc_hue_split.sv -----
// Stage 1: clamp saturation and value, split hue into sector and remainder.
`default_nettype none

module hsvc_hue_split (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [hsvc_pkg::HUE_W-1:0]    hue,
   input  wire logic [hsvc_pkg::FIELD_W-1:0]  saturation,
   input  wire logic [hsvc_pkg::FIELD_W-1:0]  brightness,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output hsvc_pkg::split_type                out_data
);
   import hsvc_pkg::*;

   logic             valid_ff;
   split_type        data_ff, data_in;
   logic [CMP_W-1:0] sat_ext, val_ext, sat_c, val_c;
   logic [SEC_W-1:0] sector;
   logic [HUE_W-1:0] base;
   logic [HUE_W-1:0] rem_full;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      sat_ext = CMP_W'(saturation);
      val_ext = CMP_W'(brightness);
      sat_c = (sat_ext > CMP_W'(ONE)) ? CMP_W'(ONE) : sat_ext;
      val_c = (val_ext > CMP_W'(ONE)) ? CMP_W'(ONE) : val_ext;

      sector = '0;
      base = '0;
      for (int k = 1; k <= SECTOR_MAX; k++) begin
         if (hue >= HUE_W'(k * HUE_PER_SECTOR)) begin
            sector = SEC_W'(k);
            base = HUE_W'(k * HUE_PER_SECTOR);
         end
      end
      rem_full = hue - base;

      data_in.sat = sat_c[CW-1:0];
      data_in.val = val_c[CW-1:0];
      data_in.sector = sector;
      data_in.rem = rem_full[REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

`default_nettype wire

// ----- hdl/hsvc_term_calc.sv -----
// Stages 2 and 3: hue fraction and p, then the q and t scale factors.
`default_nettype none

module hsvc_term_calc (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire hsvc_pkg::split_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output hsvc_pkg::term_type        out_data
);
   import hsvc_pkg::*;

   logic     f_valid_ff, t_valid_ff;
   logic     f_ready;
   frac_type f_ff, f_in;
   term_type t_ff, t_in;

   logic [X_W-1:0]             x;
   logic [X_W+RECIP_W-1:0]     recip_prod;
   logic [2*CW-1:0]            p_prod;
   logic [CW+FRAC_BITS-1:0]    sf_prod;
   logic [2*CW-1:0]            sg_prod;
   logic [CW-1:0]              one_minus_f;

   // stage 2
   always_comb begin
      x = {in_data.rem, (FRAC_BITS - SECTOR_SHIFT)'(0)};
      recip_prod = (X_W+RECIP_W)'(x) * (X_W+RECIP_W)'(RECIP);
      p_prod = (2*CW)'(in_data.val) * (2*CW)'(ONE - in_data.sat);
      f_in.sat = in_data.sat;
      f_in.val = in_data.val;
      f_in.sector = in_data.sector;
      f_in.frac = recip_prod[RECIP_SHIFT +: FRAC_BITS];
      f_in.p = p_prod[FRAC_BITS +: CW];
   end

   // stage 3
   always_comb begin
      one_minus_f = ONE - CW'(f_ff.frac);
      sf_prod = (CW+FRAC_BITS)'(f_ff.sat) * (CW+FRAC_BITS)'(f_ff.frac);
      sg_prod = (2*CW)'(f_ff.sat) * (2*CW)'(one_minus_f);
      t_in.val = f_ff.val;
      t_in.sector = f_ff.sector;
      t_in.p = f_ff.p;
      t_in.q_fac = ONE - sf_prod[FRAC_BITS +: CW];
      t_in.t_fac = ONE - sg_prod[FRAC_BITS +: CW];
   end

   assign f_ready = !t_valid_ff || out_ready;
   assign in_ready = !f_valid_ff || f_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         t_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            f_valid_ff <= in_valid;
         end
         if (f_ready) begin
            t_valid_ff <= f_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         f_ff <= f_in;
      end
      if (f_ready && f_valid_ff) begin
         t_ff <= t_in;
      end
   end

   assign out_valid = t_valid_ff;
   assign out_data = t_ff;

endmodule

`default_nettype wire

// ----- hdl/hsvc_mix.sv -----
// Stage 4: form q and t, route terms to red, green and blue; output register.
`default_nettype none

module hsvc_mix (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire hsvc_pkg::term_type            in_data,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [hsvc_pkg::FIELD_W-1:0]       red,
   output logic [hsvc_pkg::FIELD_W-1:0]       green,
   output logic [hsvc_pkg::FIELD_W-1:0]       blue
);
   import hsvc_pkg::*;

   logic               valid_ff;
   logic [2*CW-1:0]    q_prod, t_prod;
   logic [CW-1:0]      v, p, q, t;
   logic [CW-1:0]      r_sel, g_sel, b_sel;
   logic [FIELD_W-1:0] red_ff, green_ff, blue_ff;

   always_comb begin
      q_prod = (2*CW)'(in_data.val) * (2*CW)'(in_data.q_fac);
      t_prod = (2*CW)'(in_data.val) * (2*CW)'(in_data.t_fac);
      v = in_data.val;
      p = in_data.p;
      q = q_prod[FRAC_BITS +: CW];
      t = t_prod[FRAC_BITS +: CW];
      unique case (in_data.sector)
         SEC_RED: begin
            r_sel = v; g_sel = t; b_sel = p;
         end
         SEC_YELLOW: begin
            r_sel = q; g_sel = v; b_sel = p;
         end
         SEC_GREEN: begin
            r_sel = p; g_sel = v; b_sel = t;
         end
         SEC_CYAN: begin
            r_sel = p; g_sel = q; b_sel = v;
         end
         SEC_BLUE: begin
            r_sel = t; g_sel = p; b_sel = v;
         end
         default: begin
            r_sel = v; g_sel = p; b_sel = q;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         red_ff <= to_field(r_sel);
         green_ff <= to_field(g_sel);
         blue_ff <= to_field(b_sel);
      end
   end

   assign out_valid = valid_ff;
   assign red = red_ff;
   assign green = green_ff;
   assign blue = blue_ff;

endmodule

`default_nettype wire
